[hw/rtl/play_count_table_lfu_assert.svh]
// Assertion macros for the play count table.
`ifndef PLAY_COUNT_TABLE_LFU_ASSERT_SVH
`define PLAY_COUNT_TABLE_LFU_ASSERT_SVH
// Implication checked on every clock edge outside reset.
`define PCT_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("assertion failed");
// Next-cycle implication checked outside reset.
`define PCT_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("assertion failed");
`endif

[hw/rtl/pct_pkg.sv]
// Shared types and constants for the play count table.
`default_nettype none
package pct_pkg;
  localparam int unsigned TableDepthDef = 256;
  localparam int unsigned RingDepthDef  = 64;
  localparam logic [2:0] ReqRecord = 3'd0;
  localparam logic [2:0] ReqLookup = 3'd1;
  localparam logic [2:0] ReqRemove = 3'd2;
  localparam logic [2:0] ReqRecent = 3'd3;
  localparam logic [2:0] ReqClear  = 3'd4;
  localparam logic [31:0] CountMax = 32'hFFFF_FFFF;
  typedef struct packed {
    logic [31:0] key;
    logic [31:0] count;
    logic [31:0] last;
    logic [31:0] first;
  } entry_t;
endpackage
`default_nettype wire

[hw/rtl/play_count_table_lfu.sv]
// Top level of the play count table with LFU replacement and recent ring.
`default_nettype none
`include "play_count_table_lfu_assert.svh"
// One request at a time: busy is high from the transfer until the result strobe.
// Record, lookup and remove walk the entry memory one slot per cycle through a
// single read port and one compare unit. Remove also moves each entry above the
// removed one down, reading it and then writing it a slot lower, and then walks
// the ring to fix the indices it holds. The result is on the ports for one cycle
// with done_o; it cannot be stalled.
module play_count_table_lfu #(
  parameter int unsigned TableDepth = pct_pkg::TableDepthDef,
  parameter int unsigned RingDepth  = pct_pkg::RingDepthDef
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        start,
  output logic             busy,
  input  wire logic [2:0]  req_type_i,
  input  wire logic [31:0] key_hash_i,
  input  wire logic [31:0] now_time_i,
  input  wire logic [5:0]  recent_offset_i,
  output logic             done_o,
  output logic             found_o,
  output logic [31:0]      key_out_o,
  output logic [31:0]      play_count_o,
  output logic [7:0]       entry_index_o,
  output logic [31:0]      last_time_o,
  output logic [31:0]      first_time_o,
  output logic [8:0]       entry_total_o,
  output logic             replaced_o
);
  import pct_pkg::*;

  localparam int unsigned AW = $clog2(TableDepth);
  localparam int unsigned CW = $clog2(TableDepth + 1);
  localparam int unsigned RW = $clog2(RingDepth);
  localparam int unsigned FW = $clog2(RingDepth + 1);

  localparam logic [3:0] StIdle   = 4'd0;
  localparam logic [3:0] StScan   = 4'd1;
  localparam logic [3:0] StScanW  = 4'd2;
  localparam logic [3:0] StDecide = 4'd3;
  localparam logic [3:0] StRead   = 4'd4;
  localparam logic [3:0] StReadW  = 4'd5;
  localparam logic [3:0] StReport = 4'd6;
  localparam logic [3:0] StShift  = 4'd7;
  localparam logic [3:0] StShiftW = 4'd8;
  localparam logic [3:0] StRing   = 4'd9;
  localparam logic [3:0] StDone   = 4'd10;
  localparam logic [3:0] StRecent = 4'd11;

  logic [3:0]    state_q, state_d;
  logic [2:0]    req_q;
  logic [31:0]   key_q, now_q;
  logic [5:0]    off_q;
  logic [CW-1:0] used_q, used_d;
  logic [AW:0]   idx_q, idx_d;     // scan address, one bit wider for the end mark
  logic [AW-1:0] cand_q, cand_d;   // pipelined address of data on rdata
  logic          cand_v_q, cand_v_d;
  logic          hit_q, hit_d;
  logic [AW-1:0] slot_q, slot_d;
  logic [31:0]   best_q, best_d;
  logic [AW-1:0] best_i_q, best_i_d;
  logic          repl_q, repl_d;
  logic [RW:0]   rcnt_q, rcnt_d;

  logic          ring_v_q   [RingDepth];
  logic [RW-1:0] head_q;
  logic [FW-1:0] fill_q;

  // outputs
  logic          done_q, found_q, orepl_q;
  entry_t        oent_q;
  logic [AW-1:0] oidx_q;

  // memory
  logic          we;
  logic [AW-1:0] waddr, raddr;
  entry_t        wdata, rdata;

  pct_ram #(.Width($bits(entry_t)), .Depth(TableDepth)) u_ram (
    .clk_i(clk_i), .we_i(we), .waddr_i(waddr), .wdata_i(wdata),
    .raddr_i(raddr), .rdata_o(rdata)
  );

  // ring of recent entry indices
  logic          ring_we;
  logic [RW-1:0] ring_waddr, ring_raddr;
  logic [AW-1:0] ring_wdata, ring_rdata;

  pct_ram #(.Width(AW), .Depth(RingDepth)) u_ring (
    .clk_i(clk_i), .we_i(ring_we), .waddr_i(ring_waddr), .wdata_i(ring_wdata),
    .raddr_i(ring_raddr), .rdata_o(ring_rdata)
  );

  logic accept;
  assign accept = start && !busy;
  assign busy   = (state_q != StIdle);

  logic full;
  assign full = (used_q >= CW'(TableDepth));

  // read recent position
  logic [RW-1:0] rpos;
  assign rpos = head_q - RW'(off_q);
  logic off_ok;
  always_comb begin
    off_ok = ({26'd0, off_q} < 32'(fill_q));
  end

  logic [31:0] cnt_inc;
  assign cnt_inc = (rdata.count == CountMax) ? CountMax : rdata.count + 32'd1;

  logic          ring_push, ring_fix, ring_clr;

  always_comb begin
    state_d  = state_q;
    used_d   = used_q;
    idx_d    = idx_q;
    cand_d   = cand_q;
    cand_v_d = 1'b0;
    hit_d    = hit_q;
    slot_d   = slot_q;
    best_d   = best_q;
    best_i_d = best_i_q;
    repl_d   = repl_q;
    rcnt_d   = rcnt_q;
    we       = 1'b0;
    waddr    = slot_q;
    wdata    = rdata;
    raddr    = idx_q[AW-1:0];
    ring_push = 1'b0;
    ring_fix  = 1'b0;
    ring_clr  = 1'b0;
    unique case (state_q)
      StIdle: begin
        if (accept) begin
          idx_d  = '0;
          hit_d  = 1'b0;
          repl_d = 1'b0;
          best_d = CountMax;
          best_i_d = '0;
          unique case (req_type_i)
            ReqRecord, ReqLookup, ReqRemove: state_d = StScan;
            ReqRecent: state_d = StRecent;
            ReqClear:  state_d = StDone;
            default:   state_d = StDone;
          endcase
        end
      end
      StScan: begin
        // issue one read per cycle; compare the previous one
        if (cand_v_q && !hit_q) begin
          if (CW'(cand_q) < used_q && rdata.key == key_q) begin
            hit_d = 1'b1; slot_d = cand_q;
          end
          if (rdata.count < best_q) begin
            best_d = rdata.count; best_i_d = cand_q;
          end
        end
        if (hit_d || idx_q[AW] || (CW'(idx_q) >= used_q)) begin
          state_d = StScanW;
        end else begin
          cand_d = idx_q[AW-1:0]; cand_v_d = 1'b1;
          idx_d  = idx_q + 1'b1;
        end
      end
      StScanW: begin
        if (cand_v_q && !hit_q) begin
          if (rdata.key == key_q) begin
            hit_d = 1'b1; slot_d = cand_q;
          end
          if (rdata.count < best_q) begin
            best_d = rdata.count; best_i_d = cand_q;
          end
        end
        state_d = StDecide;
      end
      StDecide: begin
        if (req_q == ReqRecord) begin
          if (!hit_q) begin
            if (full) begin
              slot_d = best_i_q; repl_d = 1'b1;
            end else begin
              slot_d = used_q[AW-1:0]; used_d = used_q + 1'b1;
            end
          end
          state_d = StRead;
        end else if (hit_q) begin
          state_d = StRead;
        end else begin
          state_d = StDone;
        end
        if (req_q == ReqRecent) state_d = StRead;
      end
      StRecent: state_d = StRead;
      StRead: begin
        if (req_q == ReqRecent) begin
          // ring_rdata holds the ring slot at rpos
          raddr = ring_rdata;
          slot_d = ring_rdata;
          hit_d = off_ok && ring_v_q[rpos] && (CW'(ring_rdata) < used_q);
        end else begin
          raddr = slot_q;
        end
        state_d = StReadW;
      end
      StReadW: begin
        raddr = slot_q;
        state_d = StReport;
      end
      StReport: begin
        // rdata holds the entry at slot_q
        if (req_q == ReqRecord) begin
          we = 1'b1;
          if (hit_q) begin
            wdata.count = cnt_inc; wdata.last = now_q;
          end else begin
            wdata.key = key_q; wdata.count = 32'd1;
            wdata.last = now_q; wdata.first = now_q;
          end
          ring_push = 1'b1;
          state_d = StDone;
        end else if (req_q == ReqRemove) begin
          idx_d = {1'b0, slot_q};
          state_d = StShift;
        end else begin
          state_d = StDone;
        end
      end
      StShift: begin
        // move entry idx+1 down to idx: read it here, write it in StShiftW
        if (CW'(idx_q) + 1'b1 < used_q) begin
          raddr = AW'(idx_q + 1'b1);
          state_d = StShiftW;
        end else begin
          used_d = used_q - 1'b1;
          rcnt_d = '0;
          state_d = StRing;
        end
      end
      StShiftW: begin
        raddr = AW'(idx_q + 1'b1);
        we = 1'b1; waddr = idx_q[AW-1:0]; wdata = rdata;
        idx_d = idx_q + 1'b1;
        state_d = StShift;
      end
      StRing: begin
        // read slot rcnt, fix slot rcnt-1 from the data of the last read
        ring_fix = (rcnt_q != '0);
        rcnt_d = rcnt_q + 1'b1;
        if (rcnt_q == (RW+1)'(RingDepth)) state_d = StDone;
      end
      StDone: begin
        if (req_q == ReqClear) begin
          used_d = '0; ring_clr = 1'b1;
        end
        state_d = StIdle;
      end
      default: state_d = StIdle;
    endcase
  end

  logic [RW:0]   rcnt_m1;
  logic [RW-1:0] fix_a;
  logic          fix_dec;
  assign rcnt_m1    = rcnt_q - 1'b1;
  assign fix_a      = rcnt_m1[RW-1:0];
  assign fix_dec    = ring_fix && ring_v_q[fix_a] && (ring_rdata > slot_q);
  assign ring_we    = ring_push || fix_dec;
  assign ring_waddr = ring_push ? (head_q + 1'b1) : fix_a;
  assign ring_wdata = ring_push ? slot_q : (ring_rdata - 1'b1);
  assign ring_raddr = (state_q == StRing) ? rcnt_q[RW-1:0] : rpos;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= StIdle;
      used_q   <= '0;
      cand_v_q <= 1'b0;
      hit_q    <= 1'b0;
      repl_q   <= 1'b0;
      rcnt_q   <= '0;
      head_q   <= '0;
      fill_q   <= '0;
      done_q   <= 1'b0;
      found_q  <= 1'b0;
      orepl_q  <= 1'b0;
      for (int i = 0; i < RingDepth; i++) ring_v_q[i] <= 1'b0;
    end else begin
      state_q  <= state_d;
      used_q   <= used_d;
      cand_v_q <= cand_v_d;
      hit_q    <= hit_d;
      repl_q   <= repl_d;
      rcnt_q   <= rcnt_d;
      done_q   <= 1'b0;
      if (ring_push) begin
        head_q <= head_q + 1'b1;
        ring_v_q[head_q + 1'b1] <= 1'b1;
        if (fill_q != FW'(RingDepth)) fill_q <= fill_q + 1'b1;
      end
      if (ring_fix && ring_v_q[fix_a] && ring_rdata == slot_q) begin
        ring_v_q[fix_a] <= 1'b0;
      end
      if (ring_clr) begin
        head_q <= '0; fill_q <= '0;
        for (int i = 0; i < RingDepth; i++) ring_v_q[i] <= 1'b0;
      end
      if (state_q == StDone) begin
        done_q  <= 1'b1;
        found_q <= hit_q;
        orepl_q <= repl_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    req_q    <= accept ? req_type_i : req_q;
    if (accept) begin
      key_q <= key_hash_i; now_q <= now_time_i; off_q <= recent_offset_i;
    end
    cand_q   <= cand_d;
    slot_q   <= slot_d;
    best_q   <= best_d;
    best_i_q <= best_i_d;
    idx_q    <= idx_d;
    if (state_q == StReport) begin
      if (we && req_q == ReqRecord) oent_q <= wdata;
      else oent_q <= rdata;
      oidx_q <= slot_q;
    end
  end

  logic rep_ok;
  assign rep_ok = done_q && (found_q || req_q == ReqRecord) &&
                  (req_q == ReqRecord || req_q == ReqLookup ||
                   req_q == ReqRemove || req_q == ReqRecent);

  assign done_o        = done_q;
  assign found_o       = done_q && found_q;
  assign key_out_o     = rep_ok ? oent_q.key : 32'd0;
  assign play_count_o  = rep_ok ? oent_q.count : 32'd0;
  assign entry_index_o = rep_ok ? 8'(oidx_q) : 8'd0;
  assign last_time_o   = rep_ok ? oent_q.last : 32'd0;
  assign first_time_o  = rep_ok ? oent_q.first : 32'd0;
  assign entry_total_o = 9'(used_q);
  assign replaced_o    = done_q && orepl_q;

  `PCT_ASSERT_IMP(a_no_start_when_busy_done, done_o, busy == 1'b0)
  `PCT_ASSERT_NEXT(a_accept_busy, accept, busy)
  `PCT_ASSERT_IMP(a_used_bound, 1'b1, used_q <= CW'(TableDepth))
endmodule
`default_nettype wire

[hw/rtl/pct_ram.sv]
// Generic single-port-write, single-read RAM with registered read data.
`default_nettype none
module pct_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(Depth)-1:0] waddr_i,
  input  wire logic [Width-1:0]         wdata_i,
  input  wire logic [$clog2(Depth)-1:0] raddr_i,
  output logic      [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem [Depth];
  always_ff @(posedge clk_i) begin
    if (we_i) mem[waddr_i] <= wdata_i;
    rdata_o <= mem[raddr_i];
  end
endmodule
`default_nettype wire
